[design/sld_pkg.sv]
package sld_pkg;

	// Sync pair that opens every frame
	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	// Length limit after reset
	localparam logic [15:0] MAX_LEN_RESET = 16'd1736;

	// Receive phase, one-hot
	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_SEEN_AA = 7'b0000010,
		PH_CMD     = 7'b0000100,
		PH_LEN_LO  = 7'b0001000,
		PH_LEN_HI  = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_CHECK   = 7'b1000000
	} phase_t;

	// Deframer state carried from beat to beat
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  frame_command;
		logic [15:0] frame_length;
		logic [15:0] byte_count;
		logic [7:0]  running_xor;
		logic [7:0]  held_cmd;
		logic [7:0]  held_len_lo;
	} state_t;

	// One result beat
	typedef struct packed {
		logic        valid;
		logic        is_frame_end;
		logic [7:0]  command_code;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        checksum_ok;
	} result_t;

	// Next phase for a byte seen in one of the header phases
	function automatic phase_t hdr_next(phase_t ph, logic [7:0] b);
		phase_t nx;
		unique case (ph)
			PH_SEEN_AA: begin
				if (b == SYNC_SECOND) begin
					nx = PH_CMD;
				end else if (b == SYNC_FIRST) begin
					nx = PH_SEEN_AA;
				end else begin
					nx = PH_HUNT;
				end
			end
			PH_CMD:    nx = PH_LEN_LO;
			PH_LEN_LO: nx = PH_LEN_HI;
			default:   nx = (b == SYNC_FIRST) ? PH_SEEN_AA : PH_HUNT;
		endcase
		return nx;
	endfunction

endpackage

[design/sld_step.sv]
module sld_step (
	input  sld_pkg::state_t  cur,
	input  logic [7:0]       rx,
	input  logic [15:0]      max_len,
	output sld_pkg::state_t  nxt,
	output sld_pkg::result_t res
);

	logic [15:0]     len;
	logic [15:0]     count_inc;
	sld_pkg::phase_t scan1;
	sld_pkg::phase_t scan2;
	sld_pkg::phase_t scan3;

	assign len       = {rx, cur.held_len_lo};
	assign count_inc = cur.byte_count + 16'd1;

	// Rescan the three header bytes from the hunting phase on a false sync
	assign scan1 = sld_pkg::hdr_next(sld_pkg::PH_HUNT, cur.held_cmd);
	assign scan2 = sld_pkg::hdr_next(scan1, cur.held_len_lo);
	assign scan3 = sld_pkg::hdr_next(scan2, rx);

	// Advance the state and form the result for one byte
	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase)
			sld_pkg::PH_LEN_HI: begin
				if (len > max_len) begin
					nxt.phase = scan3;
					if (scan2 == sld_pkg::PH_CMD) begin
						nxt.held_cmd = rx;
					end
				end else begin
					nxt.frame_command = cur.held_cmd;
					nxt.frame_length  = len;
					nxt.byte_count    = '0;
					nxt.running_xor   = '0;
					nxt.phase = (len == 16'd0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
				end
			end
			sld_pkg::PH_PAYLOAD: begin
				res.valid        = 1'b1;
				res.command_code = cur.frame_command;
				res.payload_byte = rx;
				res.byte_index   = cur.byte_count;
				nxt.running_xor  = cur.running_xor ^ rx;
				nxt.byte_count   = count_inc;
				if (count_inc >= cur.frame_length) begin
					nxt.phase = sld_pkg::PH_CHECK;
				end
			end
			sld_pkg::PH_CHECK: begin
				res.valid        = 1'b1;
				res.is_frame_end = 1'b1;
				res.command_code = cur.frame_command;
				res.byte_index   = cur.frame_length;
				res.checksum_ok  = (cur.running_xor == rx);
				nxt.phase        = sld_pkg::PH_HUNT;
				nxt.running_xor  = '0;
				nxt.byte_count   = '0;
			end
			default: begin
				nxt.phase = sld_pkg::hdr_next(cur.phase, rx);
				if (cur.phase == sld_pkg::PH_CMD) begin
					nxt.held_cmd = rx;
				end
				if (cur.phase == sld_pkg::PH_LEN_LO) begin
					nxt.held_len_lo = rx;
				end
			end
		endcase
	end

endmodule

[design/sld_out_reg.sv]
module sld_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sld_pkg::result_t res,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             is_frame_end,
	output logic [7:0]       command_code,
	output logic [7:0]       payload_byte,
	output logic [15:0]      byte_index,
	output logic             checksum_ok,
	output logic             can_load
);

	logic valid_q;

	// Take a new beat when empty or when the current one leaves now
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load && res.valid;
		end
	end

	// Hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (can_load && load && res.valid) begin
			is_frame_end <= res.is_frame_end;
			command_code <= res.command_code;
			payload_byte <= res.payload_byte;
			byte_index   <= res.byte_index;
			checksum_ok  <= res.checksum_ok;
		end
	end

endmodule

[design/sync_length_xor_frame_deframer.sv]
// Frame deframer for a received byte stream.
// Input channel: in_valid / in_ready with rx_byte, one received byte per beat.
// The block hunts for the sync pair AA 55, reads a command byte and a
// little-endian 16-bit length, then emits one output beat per payload byte
// (is_frame_end = 0) and one verdict beat for the checksum byte
// (is_frame_end = 1, checksum_ok set when the XOR of the payload matches).
// Header bytes and false syncs produce no output beat.
// Config channel: cfg_valid / cfg_ready with cfg_data sets the length limit;
// cfg_ready is always high. Write it only while the block is idle.
// Each byte lands in the input register at the accepting edge, and its result
// is registered in the output register once that register can load a beat.
// Throughput: one byte per cycle while out_ready stays high; the byte register
// and the output register each pass one beat per cycle unless stalled.
// Reset: arst_n clears all control state, the phase returns to hunting and
// the length limit returns to 1736.
// Stall: when out_ready is low the result is held; one more byte sits in the
// input register, after which in_ready drops until the receiver takes a beat.
module sync_length_xor_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_frame_end,
	output logic [7:0]  command_code,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic        checksum_ok
);

	logic             valid_s1;
	logic [7:0]       rx_s1;
	logic [15:0]      max_len_q;
	sld_pkg::state_t  state_q;
	sld_pkg::state_t  state_nxt;
	sld_pkg::result_t res;
	logic             can_load;
	logic             advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && can_load;
	assign in_ready  = !valid_s1 || can_load;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sld_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	sld_step u_step (
		.cur     (state_q),
		.rx      (rx_s1),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Advance the frame state once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= sld_pkg::PH_HUNT;
			state_q.frame_command <= '0;
			state_q.frame_length  <= '0;
			state_q.byte_count    <= '0;
			state_q.running_xor   <= '0;
			state_q.held_cmd      <= '0;
			state_q.held_len_lo   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	sld_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.res          (res),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.is_frame_end (is_frame_end),
		.command_code (command_code),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.checksum_ok  (checksum_ok),
		.can_load     (can_load)
	);

`ifndef SYNTHESIS
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == sld_pkg::PH_PAYLOAD |-> state_q.byte_count < state_q.frame_length)
		else $error("payload count reached frame length");

	a_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == sld_pkg::PH_CHECK |-> state_q.byte_count == state_q.frame_length)
		else $error("checksum phase before payload complete");

	a_end_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_frame_end |-> payload_byte == 8'd0)
		else $error("frame end beat carries payload");

	a_data_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_frame_end |-> !checksum_ok)
		else $error("payload beat carries verdict");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |=> valid_s1 && $stable(rx_s1))
		else $error("input register lost a stalled byte");
`endif

endmodule

[verif/sync_length_xor_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module sync_length_xor_frame_deframer_tb;

	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// One expected result beat
	typedef struct packed {
		logic        is_frame_end;
		logic [7:0]  command_code;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        checksum_ok;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_ready;
	logic        is_frame_end;
	logic [7:0]  command_code;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic        checksum_ok;

	// Deframer state as predicted by the testbench
	sld_pkg::phase_t st_phase;
	logic [7:0]      st_cmd;
	logic [15:0]     st_len;
	logic [15:0]     st_count;
	logic [7:0]      st_xor;
	logic [7:0]      st_hdr [3];
	logic [15:0]     st_limit;

	frame_beat_t pending_beats[$];
	int          fail_count = 0;
	int          bytes_sent = 0;
	int          in_idle_pct = 0;
	int          out_stall_pct = 0;
	int          quiet_cycles = 0;

	sync_length_xor_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_frame_end (is_frame_end),
		.command_code (command_code),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.checksum_ok  (checksum_ok)
	);

	always #5 clk = ~clk;

	// Stall the receiver at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// Advance the header phases by one byte
	function automatic void scan_header_byte(input logic [7:0] b);
		case (st_phase)
			sld_pkg::PH_SEEN_AA: begin
				if (b == sld_pkg::SYNC_SECOND) begin
					st_phase = sld_pkg::PH_CMD;
				end else if (b != sld_pkg::SYNC_FIRST) begin
					st_phase = sld_pkg::PH_HUNT;
				end
			end
			sld_pkg::PH_CMD: begin
				st_hdr[0] = b;
				st_phase = sld_pkg::PH_LEN_LO;
			end
			sld_pkg::PH_LEN_LO: begin
				st_hdr[1] = b;
				st_phase = sld_pkg::PH_LEN_HI;
			end
			default: st_phase = (b == sld_pkg::SYNC_FIRST) ? sld_pkg::PH_SEEN_AA
				: sld_pkg::PH_HUNT;
		endcase
	endfunction

	// Predict the result of one accepted byte; returns 1 if a beat is due
	function automatic bit deframe_byte(input logic [7:0] b, output frame_beat_t beat);
		logic [15:0] len;
		logic [7:0]  h0, h1, h2;
		beat = '0;
		case (st_phase)
			sld_pkg::PH_LEN_HI: begin
				st_hdr[2] = b;
				len = {b, st_hdr[1]};
				if (len > st_limit) begin
					// False sync: drop the pair and rescan the held header
					h0 = st_hdr[0];
					h1 = st_hdr[1];
					h2 = st_hdr[2];
					st_phase = sld_pkg::PH_HUNT;
					scan_header_byte(h0);
					scan_header_byte(h1);
					scan_header_byte(h2);
					return 1'b0;
				end
				st_cmd = st_hdr[0];
				st_len = len;
				st_count = '0;
				st_xor = '0;
				st_phase = (len == 16'd0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
				return 1'b0;
			end
			sld_pkg::PH_PAYLOAD: begin
				beat.is_frame_end = 1'b0;
				beat.command_code = st_cmd;
				beat.payload_byte = b;
				beat.byte_index = st_count;
				beat.checksum_ok = 1'b0;
				st_xor = st_xor ^ b;
				st_count = st_count + 16'd1;
				if (st_count >= st_len) begin
					st_phase = sld_pkg::PH_CHECK;
				end
				return 1'b1;
			end
			sld_pkg::PH_CHECK: begin
				beat.is_frame_end = 1'b1;
				beat.command_code = st_cmd;
				beat.payload_byte = 8'h00;
				beat.byte_index = st_len;
				beat.checksum_ok = (st_xor == b);
				st_phase = sld_pkg::PH_HUNT;
				st_xor = '0;
				st_count = '0;
				return 1'b1;
			end
			default: begin
				scan_header_byte(b);
				return 1'b0;
			end
		endcase
	endfunction

	// Send one byte, with idle gaps at the current rate
	task automatic send_byte(input logic [7:0] b);
		frame_beat_t beat;
		if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (deframe_byte(b, beat)) begin
			pending_beats.push_back(beat);
		end
		bytes_sent++;
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
	endtask

	// Hold the sender until every expected beat has come back
	task automatic pause_until_drained();
		hold_input();
		do @(posedge clk); while (pending_beats.size() != 0);
	endtask

	// Write the length limit once the block has gone quiet
	task automatic write_limit(input logic [15:0] value);
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		st_limit = value;
	endtask

	// Send sync, header, payload and checksum; header only when oversize
	task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
			input bit good_sum, input bit extra_sync);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		sum = 8'h00;
		if (extra_sync) begin
			send_byte(sld_pkg::SYNC_FIRST);
		end
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_SECOND);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		if (len > st_limit) begin
			return;
		end
		for (i = 0; i < int'(len); i++) begin
			b = 8'($urandom);
			sum = sum ^ b;
			send_byte(b);
		end
		send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	// Mostly short lengths, some up to 64, some beyond the limit
	task automatic send_random_frame();
		int lim;
		int pick;
		logic [15:0] len;
		lim = int'(st_limit);
		pick = $urandom_range(99);
		if (pick < 12 && lim != 65535) begin
			len = 16'($urandom_range(lim + 1, 65535));
		end else if (pick < 20) begin
			len = 16'($urandom_range(0, (lim < 64) ? lim : 64));
		end else begin
			len = 16'($urandom_range(0, (lim < 12) ? lim : 12));
		end
		send_frame(8'($urandom), len, $urandom_range(99) < 75, $urandom_range(99) < 15);
	endtask

	// Repeated sync byte, zero length, bad checksum, false sync with rescan
	task automatic test_sync_and_special_cases();
		in_idle_pct = 0;
		out_stall_pct = 0;
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_SECOND);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		// Length 0xFF55 is oversize; the rescan syncs on the held AA 55
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_SECOND);
		send_byte(sld_pkg::SYNC_FIRST);
		send_byte(sld_pkg::SYNC_SECOND);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'h5A);
	endtask

	// Frames, noise and cut-off headers at one idle and stall setting
	task automatic run_traffic(input int n_bytes, input int in_pct, input int out_pct);
		int start;
		int sel;
		in_idle_pct = in_pct;
		out_stall_pct = out_pct;
		pause_until_drained();
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			sel = $urandom_range(99);
			if (sel < 2) begin
				pause_until_drained();
			end else if (sel < 12) begin
				send_byte(8'($urandom));
			end else if (sel < 17) begin
				send_byte(sld_pkg::SYNC_FIRST);
				send_byte(sld_pkg::SYNC_SECOND);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
			end else begin
				send_random_frame();
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(200, 0, 0);
		write_limit(16'($urandom_range(1, 20)));
		run_traffic(200, 57, 0);
		write_limit(16'd8);
		run_traffic(200, 0, 57);
		write_limit(sld_pkg::MAX_LEN_RESET);
		run_traffic(200, 24, 24);
	endtask

	// Limit at zero, a small limit, then the top of the 16-bit range
	task automatic test_length_limits();
		in_idle_pct = 24;
		out_stall_pct = 24;
		write_limit(16'd0);
		repeat (6) send_frame(8'($urandom), 16'd0, 1'($urandom_range(1)), 1'b0);
		send_frame(8'h5A, 16'd1, 1'b1, 1'b0);
		repeat (40) send_random_frame();
		write_limit(16'd5);
		repeat (60) send_random_frame();
		in_idle_pct = 0;
		out_stall_pct = 0;
		write_limit(16'hFFFE);
		send_frame(8'hC3, 16'hFFFF, 1'b1, 1'b0);
		send_frame(8'hC4, 16'd3, 1'b1, 1'b0);
		write_limit(16'hFFFF);
		send_frame(8'hC5, 16'd4, 1'b1, 1'b0);
	endtask

	// Compare each result beat with the oldest expected one
	always @(posedge clk) begin : check_results
		frame_beat_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_beats.size() == 0) begin
				$error("result beat with none expected: command_code %0h", command_code);
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				if (is_frame_end !== want.is_frame_end) begin
					$error("is_frame_end: expected %0d, got %0d", want.is_frame_end,
						is_frame_end);
					fail_count++;
				end
				if (command_code !== want.command_code) begin
					$error("command_code: expected %0h, got %0h", want.command_code,
						command_code);
					fail_count++;
				end
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h", want.payload_byte,
						payload_byte);
					fail_count++;
				end
				if (byte_index !== want.byte_index) begin
					$error("byte_index: expected %0d, got %0d", want.byte_index, byte_index);
					fail_count++;
				end
				if (checksum_ok !== want.checksum_ok) begin
					$error("checksum_ok: expected %0d, got %0d", want.checksum_ok,
						checksum_ok);
					fail_count++;
				end
			end
		end
	end

	// End the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_data = 16'h0000;
		out_ready = 1'b0;
		st_phase = sld_pkg::PH_HUNT;
		st_cmd = '0;
		st_len = '0;
		st_count = '0;
		st_xor = '0;
		st_hdr[0] = '0;
		st_hdr[1] = '0;
		st_hdr[2] = '0;
		st_limit = sld_pkg::MAX_LEN_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_and_special_cases();
		test_random_traffic();
		test_length_limits();
		// Drain the last results, then let the pipeline settle
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sync_length_xor_frame_deframer.f]
design/sld_pkg.sv
design/sld_step.sv
design/sld_out_reg.sv
design/sync_length_xor_frame_deframer.sv
verif/sync_length_xor_frame_deframer_tb.sv
